[src/slem_pkg.sv]
// Shared constants, register indexes and beat types of the smoothed level energy meter.
package slem_pkg;

  // Field widths fixed by the interface
  localparam int unsigned SAMPLE_BITS        = 10;
  localparam int unsigned TIME_W             = 32;
  localparam int unsigned SCALE_W            = 32;
  localparam int unsigned ENERGY_W           = 48;
  localparam int unsigned VOLT_W             = 42;
  localparam int unsigned DELTA_W            = 10;
  localparam int unsigned CUTOFF_W           = 10;
  localparam int unsigned WIN_FIELD_W        = 7;
  localparam int unsigned WIN_FIELD_MAX      = 127;

  // Default window store depth
  localparam int unsigned MAX_WINDOW_DEFAULT = 64;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_DELTA = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LOW_CUTOFF   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q16    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_DECAY = CFG_IDX_W'(4);

  // Register reset values
  localparam int unsigned           WINDOW_LEN_RST   = 10;
  localparam logic [DELTA_W-1:0]    CHANGE_DELTA_RST = DELTA_W'(5);
  localparam logic [CUTOFF_W-1:0]   LOW_CUTOFF_RST   = CUTOFF_W'(100);
  localparam logic [SCALE_W-1:0]    SCALE_Q16_RST    = SCALE_W'(65536);
  localparam logic [SCALE_W-1:0]    ENERGY_DECAY_RST = SCALE_W'(65536);

  // Input beat
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_W-1:0]      now_ms;
    logic                   clear_energy;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] level;
    logic                   changed;
    logic                   running;
    logic [ENERGY_W-1:0]    energy;
    logic [TIME_W-1:0]      run_time_ms;
    logic [VOLT_W-1:0]      voltage_q16;
  } out_beat_t;

endpackage

[src/smoothed_level_energy_meter_core.sv]
// Moving-average level meter with run detection and saturating energy accumulator.
//
// Each input beat carries one sample; the block gives exactly one result beat per
// input beat. A beat takes longer from acceptance to the result register when the
// mean is above the cutoff than when it is not, since the energy multiply is
// skipped then. The time is set mostly by the bit-serial divider that forms the
// rounded mean, one quotient bit per cycle, plus the read of the window memory and
// a 16-bit-split energy multiply. One beat is processed at a time; the next beat
// is accepted in the cycle after the result register is loaded, and a stalled result
// holds the block in its last step. A finished result waits in the output register
// while the next sample is accepted. The window memory needs no clearing pass:
// an entry is read back only once the window is full. Configuration writes are
// accepted only while no beat is in flight; a write of the window length restarts
// the window.
module smoothed_level_energy_meter_core #(
  parameter int unsigned MAX_WINDOW = slem_pkg::MAX_WINDOW_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  slem_pkg::in_beat_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output slem_pkg::out_beat_t              out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [slem_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [slem_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import slem_pkg::*;

  // Derived sizes
  localparam int unsigned LEN_MAX = (MAX_WINDOW < WIN_FIELD_MAX) ? MAX_WINDOW : WIN_FIELD_MAX;
  localparam int unsigned LEN_W   = $clog2(LEN_MAX + 1);
  localparam int unsigned SLOT_W  = $clog2(MAX_WINDOW);
  localparam int unsigned SUM_W   = SAMPLE_BITS + LEN_W;
  localparam int unsigned DVD_W   = SUM_W + 1;
  localparam int unsigned CNT_W   = $clog2(DVD_W + 1);
  localparam int unsigned CMP_W   = (SLOT_W + 1 > LEN_W) ? SLOT_W + 1 : LEN_W;
  localparam int unsigned HALF_W  = TIME_W / 2;
  localparam int unsigned LO_W    = VOLT_W + HALF_W;
  localparam int unsigned PROD_W  = VOLT_W + TIME_W;
  localparam int unsigned LEN_RST = (WINDOW_LEN_RST < LEN_MAX) ? WINDOW_LEN_RST : LEN_MAX;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_PREP,
    S_DIV,
    S_MEAN,
    S_MLO,
    S_MHI,
    S_SAT,
    S_ENG,
    S_OUT
  } state_e;

  // Control and architectural state
  state_e                 state_q;
  logic [LEN_W-1:0]       len_q;
  logic [DELTA_W-1:0]     delta_q;
  logic [CUTOFF_W-1:0]    cutoff_q;
  logic [SCALE_W-1:0]     scale_q;
  logic [SCALE_W-1:0]     decay_q;
  logic [SUM_W-1:0]       sum_q;
  logic [LEN_W-1:0]       fill_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [SAMPLE_BITS-1:0] last_rep_q;
  logic                   run_q;
  logic [TIME_W-1:0]      run_start_q;
  logic [TIME_W-1:0]      prev_time_q;
  logic [ENERGY_W-1:0]    energy_q;
  logic                   out_valid_q;

  // Per-beat working registers
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [TIME_W-1:0]      now_q;
  logic [DVD_W-1:0]       dvd_q;
  logic [LEN_W-1:0]       rem_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   chg_q;
  logic [VOLT_W-1:0]      volt_q;
  logic [TIME_W-1:0]      dt_q;
  logic [TIME_W-1:0]      run_time_q;
  logic [LO_W-1:0]        prod_lo_q;
  logic [LO_W-1:0]        prod_hi_q;
  logic [ENERGY_W-1:0]    inc_q;
  out_beat_t              out_data_q;

  // Window memory
  logic [SAMPLE_BITS-1:0] win_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_q;

  logic                   in_acc;
  logic                   out_free;
  logic [SUM_W-1:0]       sum_d;
  logic [SLOT_W-1:0]      slot_d;
  logic [CMP_W-1:0]       slot_inc;
  logic [LEN_W:0]         rem_sh;
  logic [LEN_W:0]         trial;
  logic [SAMPLE_BITS-1:0] mean;
  logic [SAMPLE_BITS-1:0] diff;
  logic                   run_now;
  logic [PROD_W-1:0]      prod_sum;
  logic [ENERGY_W:0]      energy_sum;
  logic [ENERGY_W-1:0]    decay_ext;
  logic [WIN_FIELD_W-1:0] len_wr;
  logic [LEN_W-1:0]       len_clamped;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Window sum and write pointer update
  always_comb begin
    if (fill_q < len_q) begin
      sum_d = sum_q + SUM_W'(smp_q);
    end else begin
      sum_d = sum_q - SUM_W'(rd_q) + SUM_W'(smp_q);
    end
    slot_inc = CMP_W'(slot_q) + CMP_W'(1);
    slot_d   = (slot_inc >= CMP_W'(len_q)) ? '0 : slot_inc[SLOT_W-1:0];
  end

  // Restoring divider step: one quotient bit per cycle
  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign trial  = rem_sh - {1'b0, fill_q};

  // Mean, change detect and run decision
  assign mean    = dvd_q[SAMPLE_BITS-1:0];
  assign diff    = (mean > last_rep_q) ? (mean - last_rep_q) : (last_rep_q - mean);
  assign run_now = (mean > cutoff_q);

  // Energy increment and accumulator update
  assign prod_sum   = {prod_hi_q, HALF_W'(0)} + PROD_W'(prod_lo_q);
  assign energy_sum = {1'b0, energy_q} + {1'b0, inc_q};
  assign decay_ext  = ENERGY_W'(decay_q);

  // Window length write, clamped to 1..LEN_MAX
  assign len_wr      = cfg_data_i[WIN_FIELD_W-1:0];
  assign len_clamped = (len_wr == '0) ? LEN_W'(1) :
                       ((32'(len_wr) > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(len_wr));

  // Window memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD) begin
      win_mem[slot_q] <= smp_q;
    end
    rd_q <= win_mem[slot_q];
  end

  // State machine, architectural state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= LEN_W'(LEN_RST);
      delta_q     <= CHANGE_DELTA_RST;
      cutoff_q    <= LOW_CUTOFF_RST;
      scale_q     <= SCALE_Q16_RST;
      decay_q     <= ENERGY_DECAY_RST;
      sum_q       <= '0;
      fill_q      <= '0;
      slot_q      <= '0;
      last_rep_q  <= '0;
      run_q       <= 1'b0;
      run_start_q <= '0;
      prev_time_q <= '0;
      energy_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Result beat: loaded in the last step, dropped once taken
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data_i.clear_energy) begin
              energy_q <= '0;
            end
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          sum_q  <= sum_d;
          slot_q <= slot_d;
          if (fill_q < len_q) begin
            fill_q <= fill_q + LEN_W'(1);
          end
          state_q <= S_PREP;
        end
        S_PREP: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            state_q <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (diff > delta_q) begin
            last_rep_q <= mean;
          end
          if (run_now && !run_q) begin
            run_start_q <= now_q;
          end
          run_q       <= run_now;
          prev_time_q <= now_q;
          state_q     <= run_now ? S_MLO : S_ENG;
        end
        S_MLO: begin
          state_q <= S_MHI;
        end
        S_MHI: begin
          state_q <= S_SAT;
        end
        S_SAT: begin
          state_q <= S_ENG;
        end
        S_ENG: begin
          if (run_q) begin
            energy_q <= energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
          end else begin
            energy_q <= (energy_q > decay_ext) ? (energy_q - decay_ext) : '0;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // Register writes (only while idle)
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_WINDOW_LEN: begin
            len_q  <= len_clamped;
            sum_q  <= '0;
            fill_q <= '0;
            slot_q <= '0;
          end
          REG_CHANGE_DELTA: delta_q  <= cfg_data_i[DELTA_W-1:0];
          REG_LOW_CUTOFF:   cutoff_q <= cfg_data_i[CUTOFF_W-1:0];
          REG_SCALE_Q16:    scale_q  <= cfg_data_i[SCALE_W-1:0];
          REG_ENERGY_DECAY: decay_q  <= cfg_data_i[SCALE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers for the beat in flight
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          smp_q <= in_data_i.sample;
          now_q <= in_data_i.now_ms;
        end
      end
      S_PREP: begin
        dvd_q <= DVD_W'(sum_q) + DVD_W'(fill_q >> 1);
        rem_q <= '0;
        cnt_q <= CNT_W'(DVD_W - 1);
      end
      S_DIV: begin
        if (!trial[LEN_W]) begin
          rem_q <= trial[LEN_W-1:0];
        end else begin
          rem_q <= rem_sh[LEN_W-1:0];
        end
        dvd_q <= {dvd_q[DVD_W-2:0], !trial[LEN_W]};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      S_MEAN: begin
        chg_q      <= (diff > delta_q);
        volt_q     <= VOLT_W'(mean) * VOLT_W'(scale_q);
        dt_q       <= now_q - prev_time_q;
        run_time_q <= (run_now && run_q) ? (now_q - run_start_q) : '0;
      end
      S_MLO: begin
        prod_lo_q <= LO_W'(volt_q) * LO_W'(dt_q[HALF_W-1:0]);
      end
      S_MHI: begin
        prod_hi_q <= LO_W'(volt_q) * LO_W'(dt_q[TIME_W-1:HALF_W]);
      end
      S_SAT: begin
        inc_q <= (|prod_sum[PROD_W-1:ENERGY_W]) ? '1 : prod_sum[ENERGY_W-1:0];
      end
      S_OUT: begin
        if (out_free) begin
          out_data_q.level       <= run_q ? mean : '0;
          out_data_q.changed     <= chg_q;
          out_data_q.running     <= run_q;
          out_data_q.energy      <= energy_q;
          out_data_q.run_time_ms <= run_time_q;
          out_data_q.voltage_q16 <= run_q ? volt_q : '0;
        end
      end
      default: ;
    endcase
  end

endmodule
